[sv/poc_pkg.sv]
`default_nettype none

package poc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_PORE_ATOMS_DEF  = 65536;
  localparam int unsigned EXP_TABLE_DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned LOAD_W = 16;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned WGT_W  = 17;

  // Shared divider: 80-bit dividend, 64-bit divisor
  localparam int unsigned DIV_W = 80;
  localparam int unsigned DEN_W = 64;

  typedef enum logic [1:0] {
    FUNC_PORE  = 2'd0,
    FUNC_COUNT = 2'd1,
    FUNC_EOF   = 2'd2
  } func_e_t;

  typedef enum logic [2:0] {
    CFG_PORE_RADIUS  = 3'd0,
    CFG_MOUTH_OFFSET = 3'd1,
    CFG_AXIAL_SCALE  = 3'd2,
    CFG_RADIAL_SCALE = 3'd3,
    CFG_BOX_LENGTH   = 3'd4
  } cfg_idx_e_t;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [DIV_W-1:0] quo;
  } div_res_t;

  // Magnitude of a 33-bit difference, saturated at 2^31
  function automatic logic [31:0] sat_mag(input logic signed [32:0] d);
    logic [32:0] m;
    m = d[32] ? 33'(-d) : 33'(d);
    return (m > 33'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
  endfunction

  // One Gaussian table entry from its Q31 argument u: exp(-16u) in Q16.16
  function automatic logic [WGT_W-1:0] gauss_val(input logic [63:0] u);
    logic [63:0]        t;
    logic [63:0]        p;
    logic [63:0]        v;
    logic signed [63:0] acc;
    t   = 64'd1 << 31;
    acc = 64'sh8000_0000;
    for (int k = 1; k <= 16; k++) begin
      p = (t * u) >> 31;
      case (k)
        1:       t = p;
        2:       t = p / 64'd2;
        3:       t = p / 64'd3;
        4:       t = p / 64'd4;
        5:       t = p / 64'd5;
        6:       t = p / 64'd6;
        7:       t = p / 64'd7;
        8:       t = p / 64'd8;
        9:       t = p / 64'd9;
        10:      t = p / 64'd10;
        11:      t = p / 64'd11;
        12:      t = p / 64'd12;
        13:      t = p / 64'd13;
        14:      t = p / 64'd14;
        15:      t = p / 64'd15;
        16:      t = p / 64'd16;
        default: t = p;
      endcase
      if ((k & 1) != 0) begin
        acc = acc - $signed(t);
      end else begin
        acc = acc + $signed(t);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    if (acc > 64'sh8000_0000) begin
      acc = 64'sh8000_0000;
    end
    v = $unsigned(acc);
    for (int s = 0; s < 4; s++) begin
      v = (v * v + (64'd1 << 30)) >> 31;
    end
    return WGT_W'((v + (64'd1 << 14)) >> 15);
  endfunction

endpackage

`default_nettype wire

[sv/poc_div.sv]
`default_nettype none

module poc_div
  import poc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output div_res_t              res
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign res = '{done: done_r, rem_nz: |rem_r, quo: quo_r};

endmodule

`default_nettype wire

[sv/pore_occupancy_counter_core.sv]
// Pore occupancy counter: weighted count of atoms in a z-aligned cylinder, per frame.
// Input channel (in_valid/in_ready, in_func, in_pos_x/y/z in Q16.16): per frame send
// pore atoms, then atoms to count, then one end-of-frame transaction.
// Result channel (out_valid/out_ready, out_pore_load): one transaction per frame end,
// the rounded load saturated at 65535.
// Configuration (cfg_we/cfg_idx/cfg_wdata): write only while idle; a box_length
// write takes effect at the next frame end.
// Sequencing: pore atoms and frame ends need no sequencer work. An atom to count
// runs the squaring states; the first count atom after new pore atoms first runs
// two divisions to rebuild the centre, and an atom near a mouth runs two more.
// These divisions use the shared 80-step restoring divider; one 32x32 multiplier
// handles all squares in turn. No new input is taken until the sequencer idles.
// Reset clears the frame accumulators and loads register defaults; the Gaussian
// table is a constant ROM and needs no fill. A stalled receiver holds the result
// in the output register; pore and count transactions are still taken, and only
// a further frame end waits until the result is taken.
`default_nettype none

module pore_occupancy_counter_core
  import poc_pkg::*;
#(
  parameter int unsigned MAX_PORE_ATOMS  = MAX_PORE_ATOMS_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_func,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_pos_z,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [LOAD_W-1:0]            out_pore_load,
  input  wire logic                    cfg_we,
  input  wire logic [2:0]              cfg_idx,
  input  wire logic [CFG_W-1:0]        cfg_wdata
);

  localparam int unsigned CNT_W  = $clog2(MAX_PORE_ATOMS + 1);
  localparam int unsigned SUM_W  = POS_W + CNT_W;
  localparam int unsigned TAB_AW = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_CX_W = 16'h0002,
    ST_CY_W = 16'h0004,
    ST_SQX  = 16'h0008,
    ST_SQY  = 16'h0010,
    ST_SQZH = 16'h0020,
    ST_SQZL = 16'h0040,
    ST_SQR  = 16'h0080,
    ST_SQO  = 16'h0100,
    ST_TEST = 16'h0200,
    ST_SQR0 = 16'h0400,
    ST_DA   = 16'h0800,
    ST_DA_W = 16'h1000,
    ST_DB_W = 16'h2000,
    ST_TAB  = 16'h4000,
    ST_ADD  = 16'h8000
  } state_e_t;

  // Configuration registers
  logic [CFG_W-1:0] pore_radius_r;
  logic [CFG_W-1:0] mouth_offset_r;
  logic [CFG_W-1:0] axial_scale_r;
  logic [CFG_W-1:0] radial_scale_r;
  logic [CFG_W-1:0] box_length_r;

  // Frame accumulators and the cached centre
  logic signed [SUM_W-1:0] sum_x_r;
  logic signed [SUM_W-1:0] sum_y_r;
  logic signed [POS_W-1:0] low_z_r;
  logic signed [POS_W-1:0] high_z_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [ACC_W-1:0]        wl_r;
  logic [ACC_W-1:0]        wl_nxt;
  logic                    cen_valid_r;
  logic signed [POS_W-1:0] cx_r;
  logic signed [POS_W-1:0] cy_r;

  // Item under work and sequencer scratch
  state_e_t                state_r;
  state_e_t                state_nxt;
  logic signed [POS_W-1:0] px_r;
  logic signed [POS_W-1:0] py_r;
  logic signed [POS_W-1:0] pz_r;
  logic [63:0]             rr_r;
  logic [63:0]             dzh_r;
  logic [63:0]             dzl_r;
  logic [63:0]             r0sq_r;
  logic                    in_cyl_r;
  logic                    hit_two_r;
  logic [24:0]             a_r;
  logic [33:0]             e_r;
  logic [WGT_W-1:0]        w_r;
  logic                    wzero_r;
  logic [63:0]             mul_p_r;

  logic                    out_valid_r;
  logic [LOAD_W-1:0]       out_load_r;

  logic                    in_acc;
  logic                    acc_pore;
  logic                    acc_count;
  logic                    acc_eof;

  // Shared divider
  logic                    div_start;
  logic [DIV_W-1:0]        div_dvd;
  logic [DEN_W-1:0]        div_dvs;
  div_res_t                div_res;
  logic [24:0]             ratio;

  // Shared multiplier operands
  logic [31:0]             mul_a;
  logic [31:0]             mul_b;

  logic signed [32:0]      dx_s;
  logic signed [32:0]      dy_s;
  logic signed [32:0]      dzh_s;
  logic signed [32:0]      dzl_s;
  logic [31:0]             dxm;
  logic [31:0]             dym;
  logic [31:0]             dzhm;
  logic [31:0]             dzlm;

  logic [SUM_W-1:0]        sum_x_mag;
  logic [SUM_W-1:0]        sum_y_mag;
  logic [POS_W-1:0]        cen_q;
  logic signed [POS_W-1:0] cen_x_nxt;
  logic signed [POS_W-1:0] cen_y_nxt;

  logic signed [34:0]      pz35;
  logic signed [34:0]      az35;
  logic signed [34:0]      span35;
  logic signed [34:0]      d35;
  logic [34:0]             dmag;
  logic [CFG_W-1:0]        z0_eff;
  logic [CFG_W-1:0]        r0_eff;

  logic                    in_span;
  logic                    hit_h;
  logic                    hit_l;

  logic [17:0]             add_val;
  logic [ACC_W:0]          wl_sum;
  logic [ACC_W:0]          rnd_sum;
  logic [24:0]             rnd_load;

  logic [39:0]             idx_prod;
  logic [TAB_AW-1:0]       tab_idx;
  logic [WGT_W-1:0]        gauss_rom [EXP_TABLE_DEPTH];

  // ---------------------------------------------------------------------------
  // Handshake: take pore and count transactions whenever the sequencer idles;
  // hold a frame end back only while the previous result is still stalled.
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE) &&
                     (!out_valid_r || out_ready || (in_func != FUNC_EOF));
  assign in_acc    = in_valid && in_ready;
  assign acc_pore  = in_acc && (in_func == FUNC_PORE);
  assign acc_count = in_acc && (in_func == FUNC_COUNT);
  assign acc_eof   = in_acc && (in_func == FUNC_EOF);

  assign out_valid     = out_valid_r;
  assign out_pore_load = out_load_r;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pore_radius_r  <= CFG_W'(65536);
      mouth_offset_r <= '0;
      axial_scale_r  <= CFG_W'(65536);
      radial_scale_r <= CFG_W'(65536);
      box_length_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_e_t'(cfg_idx))
        CFG_PORE_RADIUS:  pore_radius_r  <= cfg_wdata;
        CFG_MOUTH_OFFSET: mouth_offset_r <= cfg_wdata;
        CFG_AXIAL_SCALE:  axial_scale_r  <= cfg_wdata;
        CFG_RADIAL_SCALE: radial_scale_r <= cfg_wdata;
        CFG_BOX_LENGTH:   box_length_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Centre: floor(sum / count), built from the magnitude quotient
  // ---------------------------------------------------------------------------
  assign sum_x_mag = sum_x_r[SUM_W-1] ? SUM_W'(-sum_x_r) : SUM_W'(sum_x_r);
  assign sum_y_mag = sum_y_r[SUM_W-1] ? SUM_W'(-sum_y_r) : SUM_W'(sum_y_r);
  assign cen_q     = div_res.quo[POS_W-1:0] + POS_W'(div_res.rem_nz);
  assign cen_x_nxt = sum_x_r[SUM_W-1] ? $signed(-cen_q)
                                      : $signed(div_res.quo[POS_W-1:0]);
  assign cen_y_nxt = sum_y_r[SUM_W-1] ? $signed(-cen_q)
                                      : $signed(div_res.quo[POS_W-1:0]);

  // ---------------------------------------------------------------------------
  // Frame accumulators; frame end restarts the z span from the box length
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cnt_r       <= '0;
      low_z_r     <= $signed({1'b0, {CFG_W{1'b1}}});
      high_z_r    <= -$signed({1'b0, {CFG_W{1'b1}}});
      cen_valid_r <= 1'b1;
      cx_r        <= '0;
      cy_r        <= '0;
    end else begin
      if (acc_pore) begin
        cen_valid_r <= 1'b0;
        if (cnt_r < CNT_W'(MAX_PORE_ATOMS)) begin
          sum_x_r <= sum_x_r + SUM_W'(in_pos_x);
          sum_y_r <= sum_y_r + SUM_W'(in_pos_y);
          cnt_r   <= cnt_r + CNT_W'(1);
          if (in_pos_z > high_z_r) begin
            high_z_r <= in_pos_z;
          end
          if (in_pos_z < low_z_r) begin
            low_z_r <= in_pos_z;
          end
        end
      end
      if (acc_eof) begin
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        cnt_r       <= '0;
        low_z_r     <= $signed({1'b0, box_length_r});
        high_z_r    <= -$signed({1'b0, box_length_r});
        cen_valid_r <= 1'b1;
        cx_r        <= '0;
        cy_r        <= '0;
      end
      if ((state_r == ST_CX_W) && div_res.done) begin
        cx_r <= cen_x_nxt;
      end
      if ((state_r == ST_CY_W) && div_res.done) begin
        cy_r        <= cen_y_nxt;
        cen_valid_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Distances and mouth term operands
  // ---------------------------------------------------------------------------
  assign dx_s  = 33'(px_r) - 33'(cx_r);
  assign dy_s  = 33'(py_r) - 33'(cy_r);
  assign dzh_s = 33'(pz_r) - 33'(high_z_r);
  assign dzl_s = 33'(pz_r) - 33'(low_z_r);
  assign dxm   = sat_mag(dx_s);
  assign dym   = sat_mag(dy_s);
  assign dzhm  = sat_mag(dzh_s);
  assign dzlm  = sat_mag(dzl_s);

  assign pz35   = 35'(pz_r);
  assign az35   = pz35[34] ? -pz35 : pz35;
  assign span35 = 35'(high_z_r) - 35'(low_z_r);
  assign d35    = (az35 <<< 1) - span35;
  assign dmag   = d35[34] ? 35'(-d35) : 35'(d35);

  // A zero scale acts as the smallest nonzero value (one LSB)
  assign z0_eff = (axial_scale_r == '0) ? CFG_W'(1) : axial_scale_r;
  assign r0_eff = (radial_scale_r == '0) ? CFG_W'(1) : radial_scale_r;

  assign in_span = (pz_r >= low_z_r) && (pz_r <= high_z_r);
  assign hit_h   = (pz_r > high_z_r) && ((rr_r + dzh_r) <= mul_p_r);
  assign hit_l   = (pz_r < low_z_r) && ((rr_r + dzl_r) <= mul_p_r);

  // Ratio saturates at 256.0 in Q16.16
  assign ratio = (|div_res.quo[DIV_W-1:24]) ? 25'h100_0000 : 25'(div_res.quo[23:0]);

  // ---------------------------------------------------------------------------
  // Divider launch: centre x, centre y, axial ratio, radial ratio
  // ---------------------------------------------------------------------------
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc_count && !cen_valid_r) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(sum_x_mag);
          div_dvs   = DEN_W'(cnt_r);
        end
      end
      ST_CX_W: begin
        if (div_res.done) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(sum_y_mag);
          div_dvs   = DEN_W'(cnt_r);
        end
      end
      ST_DA: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'({dmag[33:0], 16'b0});
        div_dvs   = DEN_W'({z0_eff, 1'b0});
      end
      ST_DA_W: begin
        if (div_res.done) begin
          div_start = 1'b1;
          div_dvd   = DIV_W'({rr_r, 16'b0});
          div_dvs   = r0sq_r;
        end
      end
      default: ;
    endcase
  end

  poc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .res      (div_res)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands picked by state, product registered
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQX:  begin mul_a = dxm;  mul_b = dxm;  end
      ST_SQY:  begin mul_a = dym;  mul_b = dym;  end
      ST_SQZH: begin mul_a = dzhm; mul_b = dzhm; end
      ST_SQZL: begin mul_a = dzlm; mul_b = dzlm; end
      ST_SQR: begin
        mul_a = {1'b0, pore_radius_r};
        mul_b = {1'b0, pore_radius_r};
      end
      ST_SQO: begin
        mul_a = {1'b0, mouth_offset_r};
        mul_b = {1'b0, mouth_offset_r};
      end
      ST_SQR0: begin
        mul_a = {1'b0, r0_eff};
        mul_b = {1'b0, r0_eff};
      end
      ST_DA_W, ST_DB_W: begin
        mul_a = 32'(a_r);
        mul_b = 32'(a_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
  end

  // ---------------------------------------------------------------------------
  // Gaussian ROM, read registered
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] U_Q31 = (64'(gi) << 31) / EXP_TABLE_DEPTH;
    assign gauss_rom[gi] = gauss_val(U_Q31);
  end

  // Weight is zero once e reaches 16.0; below that the index stays in range
  assign idx_prod = 40'(e_r[19:0]) * 40'(EXP_TABLE_DEPTH);
  assign tab_idx  = TAB_AW'(idx_prod >> 20);

  // ---------------------------------------------------------------------------
  // Sequencer scratch registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
    end
    case (state_r)
      ST_SQY:  rr_r     <= mul_p_r;
      ST_SQZH: rr_r     <= rr_r + mul_p_r;
      ST_SQZL: dzh_r    <= mul_p_r;
      ST_SQR:  dzl_r    <= mul_p_r;
      ST_SQO:  in_cyl_r <= in_span && (rr_r <= mul_p_r);
      ST_TEST: hit_two_r <= hit_h && hit_l;
      ST_DA:   r0sq_r   <= mul_p_r;
      ST_DA_W: begin
        if (div_res.done) begin
          a_r <= ratio;
        end
      end
      ST_DB_W: begin
        if (div_res.done) begin
          e_r <= 34'(mul_p_r[63:16]) + 34'(ratio);
        end
      end
      ST_TAB: begin
        w_r     <= gauss_rom[tab_idx];
        wzero_r <= |e_r[33:20];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_count) begin
          state_nxt = cen_valid_r ? ST_SQX : ST_CX_W;
        end
      end
      ST_CX_W: if (div_res.done) state_nxt = ST_CY_W;
      ST_CY_W: if (div_res.done) state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_SQZH;
      ST_SQZH: state_nxt = ST_SQZL;
      ST_SQZL: state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SQO;
      ST_SQO:  state_nxt = ST_TEST;
      ST_TEST: state_nxt = (hit_h || hit_l) ? ST_SQR0 : ST_IDLE;
      ST_SQR0: state_nxt = ST_DA;
      ST_DA:   state_nxt = ST_DA_W;
      ST_DA_W: if (div_res.done) state_nxt = ST_DB_W;
      ST_DB_W: if (div_res.done) state_nxt = ST_TAB;
      ST_TAB:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Load accumulation: one inside the cylinder, the mouth weight per mouth hit
  // ---------------------------------------------------------------------------
  always_comb begin
    add_val = '0;
    case (state_r)
      ST_TEST: if (in_cyl_r) add_val = 18'd65536;
      ST_ADD: begin
        if (!wzero_r) begin
          add_val = hit_two_r ? {w_r, 1'b0} : {1'b0, w_r};
        end
      end
      default: ;
    endcase
  end

  assign wl_sum = {1'b0, wl_r} + (ACC_W+1)'(add_val);
  assign wl_nxt = wl_sum[ACC_W] ? '1 : wl_sum[ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= '0;
    end else if (acc_eof) begin
      wl_r <= '0;
    end else begin
      wl_r <= wl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: round to nearest, saturate, hold until taken
  // ---------------------------------------------------------------------------
  assign rnd_sum  = {1'b0, wl_r} + (ACC_W+1)'(32768);
  assign rnd_load = 25'(rnd_sum >> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_eof) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_eof) begin
      out_load_r <= (|rnd_load[24:16]) ? '1 : rnd_load[LOAD_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_CX_W) || (state_r == ST_CY_W) ||
                     (state_r == ST_DA_W) || (state_r == ST_DB_W))
    else $error("divider finished outside a wait state");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc_eof |=> (wl_r == '0) && (cnt_r == '0) && cen_valid_r)
    else $error("frame end left accumulators set");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PORE_ATOMS))
    else $error("pore atom count beyond limit");

  a_out_from_eof: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc_eof))
    else $error("result raised without a frame end");

endmodule

`default_nettype wire
